// ===== src/lru_key_value_cache_assert.svh =====
// Assertion macros for the LRU key/value cache.
// Included by lru_key_value_cache.sv; needs a clock and an active-low reset name.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define LKV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lru cache check failed");

// Next-cycle implication, off during reset.
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru cache check failed");

`endif

// ===== src/lru_kv_pkg.sv =====
// Types and constants for the LRU key/value cache.
// No dependencies; used by lru_key_value_cache.sv.
package lru_kv_pkg;

    localparam int KEY_W     = 32;
    localparam int VALUE_W   = 32;
    localparam int CAP_W     = 5;
    localparam int CAP_RESET = 16;

    typedef enum logic [1:0] {
        ACT_ADD      = 2'd0,
        ACT_GET      = 2'd1,
        ACT_ERASE    = 2'd2,
        ACT_CONTAINS = 2'd3
    } action_t;

    typedef struct packed {
        action_t            action;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] read_value;
    } rsp_t;

endpackage

// ===== src/lru_key_value_cache.sv =====
// LRU key/value cache: fully associative store with recency ranks and a scan sequencer.
// Depends on lru_kv_pkg and lru_key_value_cache_assert.svh.
//
// One request at a time. A request is taken only while the sequencer is idle, then a
// find pass reads every entry's key and rank from memory to get the match, its rank
// and the entry count. Add, and get or erase on a hit, run a second pass that rewrites
// the ranks that change and, for an add, places the new entry in the first free slot.
// Each pass reads the entries one at a time; the single read port of the key and rank
// memories sets the pace. The response sits in an output register, so a new request can
// start while it waits. Ranks are dense: rank 0 is the most recent entry, the highest
// rank is evicted.
`include "lru_key_value_cache_assert.svh"

module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lru_kv_pkg::CAP_W-1:0]  cfg_wr_data,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  lru_kv_pkg::req_t              req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output lru_kv_pkg::rsp_t              rsp
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int RANK_W = IDX_W;
    localparam int CAP_X  = (CNT_W > lru_kv_pkg::CAP_W) ? CNT_W : lru_kv_pkg::CAP_W;

    typedef enum logic [1:0] {
        IDLE,
        FIND,
        UPDATE,
        DONE
    } state_t;

    state_t                           state_reg, state_next;
    logic [lru_kv_pkg::CAP_W-1:0]     capacity_reg;
    lru_kv_pkg::req_t                 req_reg, req_next;
    logic [CNT_W-1:0]                 scan_reg, scan_next;
    logic                             pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]                 pipe_idx_reg, pipe_idx_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic                             hit_reg, hit_next;
    logic [IDX_W-1:0]                 slot_reg, slot_next;
    logic [RANK_W-1:0]                hit_rank_reg, hit_rank_next;
    logic [CNT_W-1:0]                 nprime_reg, nprime_next;
    logic                             evict_reg, evict_next;
    logic                             inserted_reg, inserted_next;
    logic [ENTRIES-1:0]               valid_reg, valid_next;
    logic                             rsp_valid_reg, rsp_valid_next;
    lru_kv_pkg::rsp_t                 rsp_reg, rsp_next;

    logic [lru_kv_pkg::KEY_W-1:0]     key_mem  [ENTRIES];
    logic [lru_kv_pkg::VALUE_W-1:0]   data_mem [ENTRIES];
    logic [RANK_W-1:0]                rank_mem [ENTRIES];
    logic [lru_kv_pkg::KEY_W-1:0]     key_rd_reg;
    logic [lru_kv_pkg::VALUE_W-1:0]   data_rd_reg;
    logic [RANK_W-1:0]                rank_rd_reg;

    logic [IDX_W-1:0]                 raddr;
    logic                             kv_we;
    logic                             rank_we;
    logic [RANK_W-1:0]                rank_wdata;

    logic                             scan_done;
    logic                             cur_valid;
    logic [RANK_W-1:0]                cur_rank;
    logic [RANK_W-1:0]                rank_adj;
    logic                             cur_removed;
    logic                             cur_evicted;
    logic [CNT_W-1:0]                 nprime_calc;
    logic [CAP_X-1:0]                 cap_x;
    logic [CAP_X-1:0]                 cap_eff;

    assign scan_done   = (scan_reg == CNT_W'(ENTRIES));
    assign cur_valid   = valid_reg[pipe_idx_reg];
    assign cur_rank    = rank_rd_reg;
    assign raddr       = scan_reg[IDX_W-1:0];
    assign nprime_calc = count_reg - CNT_W'(hit_reg);
    assign cap_x       = CAP_X'(capacity_reg);

    // Capacity zero acts as one, capacity above the store size saturates.
    always_comb
    begin
        if (cap_x == '0)
            cap_eff = CAP_X'(1);
        else if (cap_x > CAP_X'(ENTRIES))
            cap_eff = CAP_X'(ENTRIES);
        else
            cap_eff = cap_x;
    end

    // Rank after the matching entry leaves the order (add of a present key).
    assign rank_adj    = (hit_reg && cur_rank > hit_rank_reg) ? cur_rank - RANK_W'(1) : cur_rank;
    assign cur_removed = hit_reg && (pipe_idx_reg == slot_reg);
    assign cur_evicted = evict_reg && cur_valid && !cur_removed
                         && (CNT_W'(rank_adj) == nprime_reg - CNT_W'(1));

    assign req_stall = (state_reg != IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        scan_next      = scan_reg;
        pipe_vld_next  = 1'b0;
        pipe_idx_next  = pipe_idx_reg;
        count_next     = count_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        hit_rank_next  = hit_rank_reg;
        nprime_next    = nprime_reg;
        evict_next     = evict_reg;
        inserted_next  = inserted_reg;
        valid_next     = valid_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        kv_we          = 1'b0;
        rank_we        = 1'b0;
        rank_wdata     = '0;

        case (state_reg)
            IDLE:
            begin
                if (req_valid)
                begin
                    req_next      = req;
                    scan_next     = '0;
                    count_next    = '0;
                    hit_next      = 1'b0;
                    inserted_next = 1'b0;
                    state_next    = FIND;
                end
            end

            FIND:
            begin
                if (!scan_done)
                begin
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + CNT_W'(1);
                end
                if (pipe_vld_reg && cur_valid)
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (key_rd_reg == req_reg.key)
                    begin
                        hit_next      = 1'b1;
                        slot_next     = pipe_idx_reg;
                        hit_rank_next = cur_rank;
                    end
                end
                if (scan_done && !pipe_vld_reg)
                begin
                    nprime_next = nprime_calc;
                    evict_next  = (nprime_calc != '0) && (CAP_X'(nprime_calc) >= cap_eff);
                    scan_next   = '0;
                    if (req_reg.action == lru_kv_pkg::ACT_ADD
                        || (hit_reg && req_reg.action != lru_kv_pkg::ACT_CONTAINS))
                        state_next = UPDATE;
                    else
                        state_next = DONE;
                end
            end

            UPDATE:
            begin
                if (!scan_done)
                begin
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + CNT_W'(1);
                end
                if (pipe_vld_reg)
                begin
                    case (req_reg.action)
                        lru_kv_pkg::ACT_GET:
                        begin
                            // Move the hit to the front, push younger entries back one.
                            if (cur_removed)
                            begin
                                rank_we    = 1'b1;
                                rank_wdata = '0;
                            end
                            else if (cur_valid && cur_rank < hit_rank_reg)
                            begin
                                rank_we    = 1'b1;
                                rank_wdata = cur_rank + RANK_W'(1);
                            end
                        end
                        lru_kv_pkg::ACT_ERASE:
                        begin
                            if (cur_removed)
                                valid_next[pipe_idx_reg] = 1'b0;
                            else if (cur_valid && cur_rank > hit_rank_reg)
                            begin
                                rank_we    = 1'b1;
                                rank_wdata = cur_rank - RANK_W'(1);
                            end
                        end
                        lru_kv_pkg::ACT_ADD:
                        begin
                            if (cur_valid && !cur_removed && !cur_evicted)
                            begin
                                rank_we    = 1'b1;
                                rank_wdata = rank_adj + RANK_W'(1);
                            end
                            else if (!inserted_reg)
                            begin
                                // First slot free after removal takes the new entry.
                                valid_next[pipe_idx_reg] = 1'b1;
                                kv_we         = 1'b1;
                                rank_we       = 1'b1;
                                rank_wdata    = '0;
                                inserted_next = 1'b1;
                            end
                            else
                                valid_next[pipe_idx_reg] = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (scan_done && !pipe_vld_reg)
                    state_next = DONE;
            end

            DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_next.found   = hit_reg;
                    rsp_next.read_value = (hit_reg && req_reg.action == lru_kv_pkg::ACT_GET)
                                          ? data_rd_reg : '0;
                    state_next       = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            capacity_reg  <= lru_kv_pkg::CAP_W'(lru_kv_pkg::CAP_RESET);
            scan_reg      <= '0;
            pipe_vld_reg  <= 1'b0;
            count_reg     <= '0;
            hit_reg       <= 1'b0;
            evict_reg     <= 1'b0;
            inserted_reg  <= 1'b0;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wr_en)
                capacity_reg <= cfg_wr_data;
            scan_reg      <= scan_next;
            pipe_vld_reg  <= pipe_vld_next;
            count_reg     <= count_next;
            hit_reg       <= hit_next;
            evict_reg     <= evict_next;
            inserted_reg  <= inserted_next;
            valid_reg     <= valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        pipe_idx_reg <= pipe_idx_next;
        slot_reg     <= slot_next;
        hit_rank_reg <= hit_rank_next;
        nprime_reg   <= nprime_next;
        rsp_reg      <= rsp_next;
    end

    // Key, data and rank stores: one read address per store, one write at the scan slot.
    always_ff @(posedge clk)
    begin
        key_rd_reg  <= key_mem[raddr];
        rank_rd_reg <= rank_mem[raddr];
        data_rd_reg <= data_mem[slot_reg];
        if (kv_we)
        begin
            key_mem[pipe_idx_reg]  <= req_reg.key;
            data_mem[pipe_idx_reg] <= req_reg.value;
        end
        if (rank_we)
            rank_mem[pipe_idx_reg] <= rank_wdata;
    end

    `LKV_ASSERT_NEXT(a_accept_starts_find, clk, rst_n, req_valid && !req_stall, state_reg == FIND)
    `LKV_ASSERT_IMP(a_add_inserted, clk, rst_n, state_reg == DONE && req_reg.action == lru_kv_pkg::ACT_ADD, inserted_reg)
    `LKV_ASSERT_IMP(a_rsp_from_done, clk, rst_n, $rose(rsp_valid_reg), $past(state_reg) == DONE)
    `LKV_ASSERT_IMP(a_value_needs_hit, clk, rst_n, rsp_valid_reg && rsp_reg.read_value != '0, rsp_reg.found)

endmodule
